// ===== hdl/cwb_pkg.sv =====
`timescale 1ns / 1ps

package cwb_pkg;

   localparam int BUF_DEPTH = 32;
   localparam int IDX_W     = $clog2(BUF_DEPTH);
   localparam int CNT_W     = IDX_W + 1;
   localparam int ADDR_W    = 32;
   localparam int THR_W     = 6;
   localparam int CMP_W     = (THR_W > CNT_W) ? THR_W : CNT_W;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_EVICT = 1'b1;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [ADDR_W-1:0] wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } ram_req_type;

endpackage

// ===== hdl/coalescing_write_buffer_top.sv =====
`timescale 1ns / 1ps

// Coalescing write buffer. Write requests (req_tuser = 0) carry an address in
// req_tdata; an address already held is dropped, any other is appended in
// arrival order. When the held count reaches flush_threshold (saturated to the
// 32-entry depth, and 0 meaning every write flushes) the buffer drains: every
// held address leaves oldest first on rsp_tdata, the final one with rsp_tlast,
// and the buffer empties. An evict request (req_tuser = 1) drains the same
// way and yields nothing on an empty buffer. Addresses live in one memory with
// a single read port, scanned one entry per cycle; req_tready is high only
// while the buffer is idle, so no request is taken during a scan or drain.
// A drain sends one store request per cycle while rsp_tready stays high;
// input is held off until the last one is in the output register. No
// clearing pass follows reset. flush_threshold sits at byte address 0 of
// the csr port (reset 20).

module coalescing_write_buffer_top (
   input  logic        clock,
   input  logic        reset,
   // write / evict requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] address
   input  logic        req_tuser,   // [0] kind: 0 write, 1 evict
   // store requests
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] store_address
   output logic        rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [cwb_pkg::THR_W-1:0]  threshold_ff;
   logic [cwb_pkg::THR_W-1:0]  threshold_in;
   logic                       csr_write;
   logic                       csr_hit;
   cwb_pkg::ram_req_type       ram_req;
   logic [cwb_pkg::ADDR_W-1:0] ram_rdata;

   // one register; decode on the word index
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == 1'b0);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_write && csr_hit) begin
         threshold_in = csr_pwdata[cwb_pkg::THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= cwb_pkg::THR_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign csr_prdata = csr_hit ? 32'(threshold_ff) : '0;

   cwb_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_kind        (req_tuser),
      .req_address     (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_address     (rsp_tdata),
      .rsp_last        (rsp_tlast),
      .flush_threshold (threshold_ff),
      .ram_req         (ram_req),
      .ram_rdata       (ram_rdata)
   );

   cwb_store u_store (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

endmodule

// ===== hdl/cwb_store.sv =====
`timescale 1ns / 1ps

module cwb_store (
   input  logic                          clock,
   input  cwb_pkg::ram_req_type          ram_req,
   output logic [cwb_pkg::ADDR_W-1:0]    ram_rdata
);

   logic [cwb_pkg::ADDR_W-1:0] mem [cwb_pkg::BUF_DEPTH];
   logic [cwb_pkg::ADDR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rdata_ff <= mem[ram_req.raddr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

// ===== hdl/cwb_engine.sv =====
`timescale 1ns / 1ps

module cwb_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_kind,
   input  logic [cwb_pkg::ADDR_W-1:0]    req_address,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cwb_pkg::ADDR_W-1:0]    rsp_address,
   output logic                          rsp_last,
   input  logic [cwb_pkg::THR_W-1:0]     flush_threshold,
   output cwb_pkg::ram_req_type          ram_req,
   input  logic [cwb_pkg::ADDR_W-1:0]    ram_rdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_DRAIN
   } state_type;

   state_type                     state_ff, state_in;
   logic [cwb_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [cwb_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [cwb_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cwb_pkg::ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          last_entry;
   logic                          load;
   logic [cwb_pkg::CMP_W-1:0]     limit;
   logic [cwb_pkg::CMP_W-1:0]     count_ext;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_entry = (cwb_pkg::CNT_W'(idx_ff) + cwb_pkg::CNT_W'(1)) == count_ff;
   assign count_ext  = cwb_pkg::CMP_W'(count_ff);
   assign limit      = (cwb_pkg::CMP_W'(flush_threshold) > cwb_pkg::CMP_W'(cwb_pkg::BUF_DEPTH))
                       ? cwb_pkg::CMP_W'(cwb_pkg::BUF_DEPTH)
                       : cwb_pkg::CMP_W'(flush_threshold);
   assign load       = (state_ff == ST_DRAIN) && out_free;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_last_in  = rsp_last_ff;
      ram_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_kind == cwb_pkg::KIND_EVICT) begin
                  if (count_ff != '0) begin
                     ram_req.re = 1'b1;
                     idx_in     = '0;
                     state_in   = ST_DRAIN;
                  end
               end else begin
                  addr_in = req_address;
                  if (count_ff == '0) begin
                     // empty: append at once
                     ram_req.we    = 1'b1;
                     ram_req.wdata = req_address;
                     count_in      = cwb_pkg::CNT_W'(1);
                     state_in      = ST_CHECK;
                  end else begin
                     ram_req.re = 1'b1;
                     idx_in     = '0;
                     state_in   = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (ram_rdata == addr_ff) begin
               state_in = ST_CHECK;
            end else if (last_entry) begin
               if (count_ff < cwb_pkg::CNT_W'(cwb_pkg::BUF_DEPTH)) begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = count_ff[cwb_pkg::IDX_W-1:0];
                  ram_req.wdata = addr_ff;
                  count_in      = count_ff + cwb_pkg::CNT_W'(1);
               end
               state_in = ST_CHECK;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = idx_ff + cwb_pkg::IDX_W'(1);
               idx_in        = idx_ff + cwb_pkg::IDX_W'(1);
            end
         end
         ST_CHECK: begin
            // the check state keeps the append write ahead of any drain read
            if (count_ext >= limit) begin
               ram_req.re = 1'b1;
               idx_in     = '0;
               state_in   = ST_DRAIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = ram_rdata;
               rsp_last_in  = last_entry;
               if (last_entry) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = idx_ff + cwb_pkg::IDX_W'(1);
                  idx_in        = idx_ff + cwb_pkg::IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      addr_ff     <= addr_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready  = (state_ff == ST_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_address = rsp_addr_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cwb_pkg::CNT_W'(cwb_pkg::BUF_DEPTH))
      else $error("entry count above buffer depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_req.re |-> cwb_pkg::CNT_W'(ram_req.raddr) < count_ff)
      else $error("read of an entry that is not held");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> count_ff < cwb_pkg::CNT_W'(cwb_pkg::BUF_DEPTH))
      else $error("append into a full buffer");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (load && last_entry) |=> (count_ff == '0 && rsp_valid_ff && rsp_last_ff))
      else $error("final store request did not empty the buffer");
`endif

endmodule
